>>> design/dbp_pkg.sv
// Package for the decimal power block: shared types, constants and helpers.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps
package dbp_pkg;

	localparam int BIN_W       = 31;
	localparam int BASE_DIGITS = 10;
	localparam int BIN_CNT_W   = 5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_LOAD,
		S_ROWS,
		S_NORM,
		S_OUT
	} state_t;

	typedef struct packed {
		logic clr;
		logic mac;
		logic norm;
	} col_ctl_t;

	typedef struct packed {
		logic [3:0] digit;
		logic       digit_nz;
		logic       carry_nz;
	} col_sts_t;

	function automatic logic [31:0] div10(input logic [31:0] v);
		logic [63:0] p;
		p = 64'(v) * 64'h0000_0000_CCCC_CCCD;
		return 32'(p >> 35);
	endfunction

endpackage

>>> design/dbp_if.sv
// Request and result channel interfaces of the decimal power block.
// Depends on dbp_pkg for field widths.
`timescale 1ns / 1ps
interface dbp_in_if;
	import dbp_pkg::*;
	logic             valid;
	logic             ready;
	logic [BIN_W-1:0] base_value;
	logic [BIN_W-1:0] exponent;
	modport source (output valid, output base_value, output exponent, input ready);
	modport sink (input valid, input base_value, input exponent, output ready);
endinterface

interface dbp_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digit_group;
	logic [2:0]  group_index;
	logic [6:0]  digit_count;
	logic        overflow;
	logic        last_group;
	modport source (output valid, output digit_group, output group_index,
		output digit_count, output overflow, output last_group, input ready);
	modport sink (input valid, input digit_group, input group_index,
		input digit_count, input overflow, input last_group, output ready);
endinterface

>>> design/dbp_bin2bcd.sv
// Binary to BCD converter of the base, one input bit per cycle (shift and add 3).
// Depends on dbp_pkg.
`timescale 1ns / 1ps
module dbp_bin2bcd
	import dbp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [BIN_W-1:0]         bin,
	output logic                     busy,
	output logic [4*BASE_DIGITS-1:0] bcd
);

	logic                     run_q;
	logic [BIN_CNT_W-1:0]     cnt_q;
	logic [BIN_W-1:0]         sh_q;
	logic [4*BASE_DIGITS-1:0] bcd_q;
	logic [4*BASE_DIGITS-1:0] adj;

	always_comb begin
		for (int k = 0; k < BASE_DIGITS; k++) begin
			if (bcd_q[4*k +: 4] >= 4'd5)
				adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
			else
				adj[4*k +: 4] = bcd_q[4*k +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == BIN_CNT_W'(BIN_W - 1))
				run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= bin;
			bcd_q <= '0;
		end else if (run_q) begin
			sh_q  <= sh_q << 1;
			bcd_q <= {adj[4*BASE_DIGITS-2:0], sh_q[BIN_W-1]};
		end
	end

	assign busy = run_q;
	assign bcd  = bcd_q;

endmodule

>>> design/dbp_colunit.sv
// Shared column unit: row multiply-accumulate of one multiplier digit into
// binary column sums, then column-serial carry normalization. Depends on dbp_pkg.
`timescale 1ns / 1ps
module dbp_colunit
	import dbp_pkg::*;
#(
	parameter int MAX_DIGITS = 96
) (
	input  logic                    clk,
	input  col_ctl_t                ctl,
	input  logic [4*MAX_DIGITS-1:0] x,
	input  logic [3:0]              ydig,
	output col_sts_t                sts
);

	localparam int COL_W = $clog2(MAX_DIGITS * 81 + 1) + 1;
	localparam int NCOL  = 2 * MAX_DIGITS;

	logic [COL_W-1:0] col_q [NCOL];
	logic [COL_W-1:0] carry_q;
	logic [COL_W:0]   t;
	logic [COL_W-1:0] quo;
	logic [COL_W:0]   rem;
	logic [7:0]       prod [MAX_DIGITS];

	always_comb begin
		for (int k = 0; k < MAX_DIGITS; k++)
			prod[k] = {4'b0, ydig} * {4'b0, x[4*k +: 4]};
	end

	always_comb begin
		t   = {1'b0, col_q[0]} + {1'b0, carry_q};
		quo = COL_W'(div10(32'(t)));
		rem = t - (COL_W+1)'({quo, 3'b0}) - (COL_W+1)'({quo, 1'b0});
		sts.digit    = rem[3:0];
		sts.digit_nz = (rem[3:0] != 4'd0);
		sts.carry_nz = (quo != '0);
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			for (int k = 0; k < NCOL; k++)
				col_q[k] <= '0;
			carry_q <= '0;
		end else if (ctl.mac) begin
			col_q[0] <= COL_W'(prod[0]);
			for (int k = 1; k < NCOL; k++) begin
				if (k < MAX_DIGITS)
					col_q[k] <= col_q[k-1] + COL_W'(prod[k]);
				else
					col_q[k] <= col_q[k-1];
			end
		end else if (ctl.norm) begin
			for (int k = 0; k < NCOL - 1; k++)
				col_q[k] <= col_q[k+1];
			col_q[NCOL-1] <= '0;
			carry_q <= quo;
		end
	end

endmodule

>>> design/decimal_bignum_power.sv
// Decimal power by squaring, top level: sequencer, digit registers, result output.
// Depends on dbp_pkg, dbp_if, dbp_bin2bcd and dbp_colunit.
//
// Usage: a request on req carries base_value and exponent (31 bits each). The
// block computes base_value**exponent as MAX_DIGITS decimal digits and sends
// it on rsp as BCD groups of DIGITS_PER_GROUP digits, least significant first,
// each with group_index, digit_count, overflow and last_group. Overflow means
// the true power exceeded MAX_DIGITS digits; the digits are then the power
// modulo 10**MAX_DIGITS and digit_count is MAX_DIGITS.
// Flow: the base is first converted to BCD, then 31 squarings plus one multiply
// per set exponent bit follow, each on the shared column unit as a row phase over
// the multiplier digits followed by a carry normalization phase over the columns.
// One request is handled at a time; req.ready is high only when idle.
// Groups are held in an output register and advance one per accepted result;
// a stall on rsp holds the current group. Reset returns to idle with no result.
`timescale 1ns / 1ps
module decimal_bignum_power
	import dbp_pkg::*;
#(
	parameter int MAX_DIGITS       = 96,
	parameter int DIGITS_PER_GROUP = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	dbp_in_if.sink           req,
	dbp_out_if.source        rsp
);

	localparam int DW     = 4 * MAX_DIGITS;
	localparam int GW     = 4 * DIGITS_PER_GROUP;
	localparam int STEP_W = $clog2(2 * MAX_DIGITS);
	localparam int IDX_W  = $clog2(MAX_DIGITS);
	localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

	state_t state_q, state_nxt;

	logic [DW-1:0]          acc_q;
	logic [DW-1:0]          y_q;
	logic [BIN_W-1:0]       e_q;
	logic [BIN_CNT_W-1:0]   bit_q;
	logic                   mulb_q;
	logic                   ovf_q;
	logic [STEP_W-1:0]      step_q;
	logic [IDX_W-1:0]       nz_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       rem_q;
	logic [IDX_W-1:0]       grp_q;

	logic                   req_acc;
	logic                   rsp_acc;
	logic                   conv_busy;
	logic [4*BASE_DIGITS-1:0] base_bcd;
	col_ctl_t               ctl;
	col_sts_t               sts;
	logic                   row_last;
	logic                   norm_last;
	logic                   norm_low;
	logic                   ovf_nxt;
	logic                   grp_last;

	assign req_acc   = req.valid & req.ready;
	assign rsp_acc   = rsp.valid & rsp.ready;
	assign row_last  = (step_q == STEP_W'(MAX_DIGITS - 1));
	assign norm_last = (step_q == STEP_W'(2 * MAX_DIGITS - 1));
	assign norm_low  = (step_q < STEP_W'(MAX_DIGITS));
	assign ovf_nxt   = ovf_q | (!norm_low & sts.digit_nz) | (norm_last & sts.carry_nz);
	assign grp_last  = (rem_q <= CNT_W'(DIGITS_PER_GROUP));

	dbp_bin2bcd u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (req_acc),
		.bin    (req.base_value),
		.busy   (conv_busy),
		.bcd    (base_bcd)
	);

	dbp_colunit #(.MAX_DIGITS(MAX_DIGITS)) u_col (
		.clk  (clk),
		.ctl  (ctl),
		.x    (acc_q),
		.ydig (y_q[DW-1 -: 4]),
		.sts  (sts)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: if (req_acc) state_nxt = S_CONV;
			S_CONV: if (!conv_busy) state_nxt = S_LOAD;
			S_LOAD: state_nxt = S_ROWS;
			S_ROWS: if (row_last) state_nxt = S_NORM;
			S_NORM: begin
				if (norm_last) begin
					if ((!mulb_q && e_q[bit_q]) || bit_q != '0)
						state_nxt = S_LOAD;
					else
						state_nxt = S_OUT;
				end
			end
			S_OUT: if (rsp_acc && grp_last) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		rsp.valid = 1'b0;
		ctl       = '0;
		unique case (state_q)
			S_IDLE: req.ready = 1'b1;
			S_LOAD: ctl.clr = 1'b1;
			S_ROWS: ctl.mac = 1'b1;
			S_NORM: ctl.norm = 1'b1;
			S_OUT:  rsp.valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			bit_q   <= '0;
			mulb_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						bit_q  <= BIN_CNT_W'(BIN_W - 1);
						mulb_q <= 1'b0;
						ovf_q  <= 1'b0;
					end
				end
				S_LOAD: step_q <= '0;
				S_ROWS: step_q <= row_last ? '0 : step_q + 1'b1;
				S_NORM: begin
					step_q <= step_q + 1'b1;
					ovf_q  <= ovf_nxt;
					if (norm_last) begin
						if (!mulb_q && e_q[bit_q]) begin
							mulb_q <= 1'b1;
						end else if (bit_q != '0) begin
							mulb_q <= 1'b0;
							bit_q  <= bit_q - 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					e_q   <= req.exponent;
					acc_q <= DW'(1);
				end
			end
			S_LOAD: begin
				y_q  <= mulb_q ? DW'(base_bcd) : acc_q;
				nz_q <= '0;
			end
			S_ROWS: y_q <= y_q << 4;
			S_NORM: begin
				if (norm_low) begin
					acc_q <= {sts.digit, acc_q[DW-1:4]};
					if (sts.digit_nz)
						nz_q <= IDX_W'(step_q);
				end
				if (norm_last) begin
					cnt_q <= ovf_nxt ? CNT_W'(MAX_DIGITS) : CNT_W'(nz_q) + 1'b1;
					rem_q <= ovf_nxt ? CNT_W'(MAX_DIGITS) : CNT_W'(nz_q) + 1'b1;
					grp_q <= '0;
				end
			end
			S_OUT: begin
				if (rsp_acc) begin
					acc_q <= acc_q >> GW;
					rem_q <= rem_q - CNT_W'(DIGITS_PER_GROUP);
					grp_q <= grp_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign rsp.digit_group = 64'(acc_q[GW-1:0]);
	assign rsp.group_index = 3'(grp_q);
	assign rsp.digit_count = 7'(cnt_q);
	assign rsp.overflow    = ovf_q;
	assign rsp.last_group  = grp_last;

endmodule

>>> bench/tb.sv
// Self-checking testbench for decimal_bignum_power: a table of directed requests
// followed by random ones, checked against fixed expectations or a digit-array power model.
// Depends on dbp_pkg, dbp_if and the design files.
`timescale 1ns / 1ps
module tb;
	import dbp_pkg::*;

	localparam int NDIG = 96;
	localparam int GDIG = 16;
	localparam int N_RANDOM = 80;

	typedef struct {
		logic [63:0] digits;
		logic [2:0]  index;
		logic [6:0]  count;
		logic        ovf;
		logic        last;
	} group_t;

	typedef struct {
		logic [30:0] base_value;
		logic [30:0] exponent;
		bit          typed;
		logic [63:0] digits;
		logic [6:0]  count;
	} row_t;

	logic clk;
	logic arst_n;
	dbp_in_if  req ();
	dbp_out_if rsp ();

	decimal_bignum_power #(.MAX_DIGITS(NDIG), .DIGITS_PER_GROUP(GDIG)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	group_t pending_groups[$];
	int errors = 0;
	int requests_sent = 0;
	int groups_seen = 0;
	int overflows_seen = 0;
	bit calm = 0;
	bit stim_done = 0;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#80ms;
		$display("TEST FAILED");
		$finish;
	end

	// acc = acc * y mod 10^NDIG; returns one if the full product is wider
	function automatic bit mul_dec(ref int acc[NDIG], input int y[NDIG]);
		int wide[2*NDIG];
		int carry;
		int t;
		bit wider;
		carry = 0;
		wider = 0;
		foreach (wide[k]) wide[k] = 0;
		for (int i = 0; i < NDIG; i++) begin
			if (y[i] != 0) begin
				for (int j = 0; j < NDIG; j++) wide[i+j] += acc[j] * y[i];
			end
		end
		for (int i = 0; i < 2*NDIG; i++) begin
			t = wide[i] + carry;
			carry = t / 10;
			if (i < NDIG) acc[i] = t % 10;
			else if (t % 10 != 0) wider = 1;
		end
		if (carry != 0) wider = 1;
		return wider;
	endfunction

	function automatic void predict_power(input logic [30:0] b, input logic [30:0] e);
		int acc[NDIG];
		int bd[NDIG];
		int sq[NDIG];
		int cnt;
		int ngroups;
		bit ovf;
		logic [31:0] rest;
		group_t g;
		ovf = 0;
		rest = 32'(b);
		for (int i = 0; i < NDIG; i++) begin
			bd[i] = rest % 10;
			rest = rest / 10;
			acc[i] = 0;
		end
		acc[0] = 1;
		for (int bit_i = 30; bit_i >= 0; bit_i--) begin
			sq = acc;
			if (mul_dec(acc, sq)) ovf = 1;
			if (e[bit_i]) begin
				if (mul_dec(acc, bd)) ovf = 1;
			end
		end
		cnt = 1;
		if (ovf) cnt = NDIG;
		else begin
			for (int i = NDIG - 1; i > 0; i--) begin
				if (acc[i] != 0) begin
					cnt = i + 1;
					break;
				end
			end
		end
		ngroups = (cnt + GDIG - 1) / GDIG;
		for (int gi = 0; gi < ngroups; gi++) begin
			g.digits = '0;
			for (int d = 0; d < GDIG; d++) begin
				if (gi*GDIG + d < NDIG) g.digits[4*d +: 4] = 4'(acc[gi*GDIG + d]);
			end
			g.index = 3'(gi);
			g.count = 7'(cnt);
			g.ovf = ovf;
			g.last = (gi == ngroups - 1);
			pending_groups.push_back(g);
		end
	endfunction

	task automatic send_power(input row_t r);
		group_t g;
		while (!calm && $urandom_range(99) < 28) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.base_value <= r.base_value;
		req.exponent <= r.exponent;
		forever begin
			@(negedge clk);
			if (req.ready) break;
		end
		@(posedge clk);
		requests_sent++;
		if (r.typed) begin
			g.digits = r.digits;
			g.index = '0;
			g.count = r.count;
			g.ovf = 1'b0;
			g.last = 1'b1;
			pending_groups.push_back(g);
		end else begin
			predict_power(r.base_value, r.exponent);
		end
	endtask

	row_t directed[] = '{
		'{31'd0, 31'd0, 1, 64'h1, 7'd1},
		'{31'd0, 31'd5, 1, 64'h0, 7'd1},
		'{31'd5, 31'd0, 1, 64'h1, 7'd1},
		'{31'h7FFFFFFF, 31'd0, 1, 64'h1, 7'd1},
		'{31'd1, 31'h7FFFFFFF, 1, 64'h1, 7'd1},
		'{31'd0, 31'h7FFFFFFF, 1, 64'h0, 7'd1},
		'{31'd2, 31'd10, 1, 64'h1024, 7'd4},
		'{31'd7, 31'd1, 1, 64'h7, 7'd1},
		'{31'h7FFFFFFF, 31'd1, 1, 64'h2147483647, 7'd10},
		'{31'd10, 31'd15, 1, 64'h1000000000000000, 7'd16},
		'{31'd10, 31'd16, 0, 64'h0, 7'd0},
		'{31'd10, 31'd95, 0, 64'h0, 7'd0},
		'{31'd10, 31'd96, 0, 64'h0, 7'd0},
		'{31'd2, 31'd318, 0, 64'h0, 7'd0},
		'{31'd2, 31'd319, 0, 64'h0, 7'd0},
		'{31'h7FFFFFFF, 31'd9, 0, 64'h0, 7'd0},
		'{31'h7FFFFFFF, 31'd10, 0, 64'h0, 7'd0},
		'{31'h7FFFFFFF, 31'h7FFFFFFF, 0, 64'h0, 7'd0},
		'{31'h55555555, 31'h2AAAAAAA, 0, 64'h0, 7'd0},
		'{31'd3, 31'd200, 0, 64'h0, 7'd0}
	};

	initial begin
		row_t r;
		req.valid = 1'b0;
		req.base_value = '0;
		req.exponent = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[k]) send_power(directed[k]);
		for (int k = 0; k < N_RANDOM; k++) begin
			calm = (k >= 60 && k < 75);
			r.typed = 0;
			r.digits = '0;
			r.count = '0;
			case ($urandom_range(3))
				0: begin
					r.base_value = 31'($urandom);
					r.exponent = 31'($urandom_range(12));
				end
				1: begin
					r.base_value = 31'($urandom_range(30));
					r.exponent = 31'($urandom_range(120));
				end
				2: begin
					r.base_value = 31'($urandom_range(2));
					r.exponent = 31'($urandom);
				end
				default: begin
					r.base_value = 31'($urandom);
					r.exponent = 31'($urandom);
				end
			endcase
			send_power(r);
		end
		calm = 0;
		req.valid <= 1'b0;
		stim_done = 1;
	end

	// result side: random stalls, one long hold-off, and a quiet stretch
	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (requests_sent == 30) begin
				rsp.ready <= 1'b0;
				repeat (40000) @(posedge clk);
				rsp.ready <= 1'b1;
				wait (requests_sent > 30);
			end else begin
				rsp.ready <= calm || ($urandom_range(99) >= 28);
			end
		end
	end

	always @(negedge clk) begin
		group_t g;
		if (arst_n && rsp.valid && rsp.ready) begin
			groups_seen++;
			if (rsp.overflow) overflows_seen++;
			if (pending_groups.size() == 0) begin
				errors++;
				$display("%0t: unexpected group %h", $time, rsp.digit_group);
			end else begin
				g = pending_groups.pop_front();
				if (rsp.digit_group !== g.digits || rsp.group_index !== g.index ||
						rsp.digit_count !== g.count || rsp.overflow !== g.ovf ||
						rsp.last_group !== g.last) begin
					errors++;
					$display("%0t: expected %h idx %0d cnt %0d ovf %b last %b", $time,
						g.digits, g.index, g.count, g.ovf, g.last);
					$display("%0t: actual   %h idx %0d cnt %0d ovf %b last %b", $time,
						rsp.digit_group, rsp.group_index, rsp.digit_count,
						rsp.overflow, rsp.last_group);
				end
			end
		end
	end

	initial begin
		wait (stim_done);
		wait (pending_groups.size() == 0);
		repeat (200) @(posedge clk);
		$display("Covered %0d power requests, %0d result groups, %0d with overflow.",
			requests_sent, groups_seen, overflows_seen);
		if (errors == 0 && pending_groups.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
